### sv/idrq_pkg.sv
`default_nettype none

package idrq_pkg;

   // Limits of a signed 32-bit value.
   localparam logic [31:0] S32_POS_LIMIT = 32'h7fff_ffff;
   localparam logic [31:0] S32_NEG_LIMIT = 32'h8000_0000;

   // Rounding constant of the Q31 high multiply.
   localparam logic [63:0] HALF_Q31 = 64'h0000_0000_4000_0000;

   // Register indexes of the configuration port.
   localparam logic [1:0] CSR_INPUT_ZP  = 2'd0;
   localparam logic [1:0] CSR_OUTPUT_ZP = 2'd1;
   localparam logic [1:0] CSR_RELU_EN   = 2'd2;

   // Saturation bounds of an int8 result.
   localparam logic signed [32:0] S8_POS_LIMIT = 33'sd127;
   localparam logic signed [32:0] S8_NEG_LIMIT = -33'sd128;

   // Configuration registers.
   typedef struct packed {
      logic signed [7:0] in_zero_pt;
      logic signed [7:0] out_zero_pt;
      logic              relu_en;
   } cfg_type;

   // One finished dot product waiting for requantization.
   typedef struct packed {
      logic [31:0] sum;
      logic [31:0] multiplier;
      logic [4:0]  shift;
   } job_type;

   // Queue status seen by its producer and consumer.
   typedef struct packed {
      logic full;
      logic empty;
   } queue_status_type;

   // Requantization sequencer states.
   typedef enum logic [2:0] {
      ST_IDLE,
      ST_MUL,
      ST_HMUL,
      ST_RSH,
      ST_OUT
   } back_state_type;

endpackage

`default_nettype wire

### sv/int8_dense_requant_mac.sv
// Dot product terms transfer at one per cycle while the queue is not full; a non-last
// term is absorbed in its cycle, and a last term's sum is pushed into the queue.
// The requantization sequencer handles one neuron at a time; a 2-entry queue buffers neurons.
// Sync reset zeroes accumulator and configuration, idles the sequencer, empties the queue.
`default_nettype none

module int8_dense_requant_mac
   import idrq_pkg::*;
#(
   parameter int QUEUE_DEPTH = 2
) (
   input  wire logic              clock,
   input  wire logic              reset,
   input  wire logic              csr_valid,
   output logic                   csr_ready,
   input  wire logic [1:0]        csr_index,
   input  wire logic [7:0]        csr_wdata,
   input  wire logic              req_valid,
   output logic                   req_ready,
   input  wire logic signed [7:0] req_activation,
   input  wire logic signed [7:0] req_weight,
   input  wire logic signed [7:0] req_weight_zero_point,
   input  wire logic [31:0]       req_bias,
   input  wire logic [31:0]       req_multiplier,
   input  wire logic [4:0]        req_shift,
   input  wire logic              req_last_term,
   output logic                   rsp_valid,
   input  wire logic              rsp_ready,
   output logic signed [7:0]      rsp_neuron_out
);

   cfg_type          cfg_ff, cfg_in;
   queue_status_type q_status;
   logic             q_push;
   logic             q_pop;
   job_type          q_push_job;
   job_type          q_head;

   // Configuration writes are always taken; unknown indexes are dropped.
   assign csr_ready = 1'b1;

   always_comb begin
      cfg_in = cfg_ff;
      if (csr_valid) begin
         unique case (csr_index)
            CSR_INPUT_ZP:  cfg_in.in_zero_pt  = csr_wdata;
            CSR_OUTPUT_ZP: cfg_in.out_zero_pt = csr_wdata;
            CSR_RELU_EN:   cfg_in.relu_en     = csr_wdata[0];
            default: begin
               cfg_in = cfg_ff;
            end
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff <= '0;
      end else begin
         cfg_ff <= cfg_in;
      end
   end

   // Accumulation front end.
   idrq_front u_front (
      .clock                 (clock),
      .reset                 (reset),
      .cfg                   (cfg_ff),
      .req_valid             (req_valid),
      .req_ready             (req_ready),
      .req_activation        (req_activation),
      .req_weight            (req_weight),
      .req_weight_zero_point (req_weight_zero_point),
      .req_bias              (req_bias),
      .req_multiplier        (req_multiplier),
      .req_shift             (req_shift),
      .req_last_term         (req_last_term),
      .q_status              (q_status),
      .q_push                (q_push),
      .q_job                 (q_push_job)
   );

   // Finished sums waiting for requantization.
   idrq_queue #(
      .DEPTH (QUEUE_DEPTH)
   ) u_queue (
      .clock    (clock),
      .reset    (reset),
      .push     (q_push),
      .push_job (q_push_job),
      .pop      (q_pop),
      .head_job (q_head),
      .status   (q_status)
   );

   // Requantization back end.
   idrq_back u_back (
      .clock          (clock),
      .reset          (reset),
      .cfg            (cfg_ff),
      .q_status       (q_status),
      .q_head         (q_head),
      .q_pop          (q_pop),
      .rsp_valid      (rsp_valid),
      .rsp_ready      (rsp_ready),
      .rsp_neuron_out (rsp_neuron_out)
   );

   // The queue never takes a push while full, nor a pop while empty.
   assert property (@(posedge clock) disable iff (reset) !(q_push && q_status.full))
      else $error("push into a full queue");

   assert property (@(posedge clock) disable iff (reset) !(q_pop && q_status.empty))
      else $error("pop from an empty queue");

   // No result is offered right after reset.
   assert property (@(posedge clock) reset |=> !rsp_valid)
      else $error("result valid after reset");

   // With ReLU on, a newly loaded result never lies below the output zero point.
   assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && !$past(rsp_valid) && cfg_ff.relu_en && $stable(cfg_ff))
         |-> (rsp_neuron_out >= cfg_ff.out_zero_pt))
      else $error("ReLU floor violated");

endmodule

`default_nettype wire

### sv/idrq_front.sv
`default_nettype none

module idrq_front
   import idrq_pkg::*;
(
   input  wire logic              clock,
   input  wire logic              reset,
   input  wire cfg_type           cfg,
   input  wire logic              req_valid,
   output logic                   req_ready,
   input  wire logic signed [7:0] req_activation,
   input  wire logic signed [7:0] req_weight,
   input  wire logic signed [7:0] req_weight_zero_point,
   input  wire logic [31:0]       req_bias,
   input  wire logic [31:0]       req_multiplier,
   input  wire logic [4:0]        req_shift,
   input  wire logic              req_last_term,
   input  wire queue_status_type  q_status,
   output logic                   q_push,
   output job_type                q_job
);

   logic [31:0]        acc_ff;
   logic [31:0]        acc_in;
   logic signed [8:0]  x_term;
   logic signed [8:0]  w_term;
   logic signed [17:0] product;
   logic [31:0]        acc_sum;
   logic               accept;

   // Items are taken whenever the queue can hold a finished neuron.
   assign req_ready = !q_status.full;
   assign accept    = req_valid && req_ready;

   // Offset both operands by their zero points and multiply.
   assign x_term  = {req_activation[7], req_activation}
                  - {cfg.in_zero_pt[7], cfg.in_zero_pt};
   assign w_term  = {req_weight[7], req_weight}
                  - {req_weight_zero_point[7], req_weight_zero_point};
   assign product = x_term * w_term;
   assign acc_sum = acc_ff + {{14{product[17]}}, product};

   // On the last term the bias is folded in and the sum is handed to the back end.
   assign q_push           = accept && req_last_term;
   assign q_job.sum        = acc_sum + req_bias;
   assign q_job.multiplier = req_multiplier;
   assign q_job.shift      = req_shift;

   // The accumulator wraps and is cleared after each neuron.
   always_comb begin
      acc_in = acc_ff;
      if (accept) begin
         acc_in = req_last_term ? 32'd0 : acc_sum;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         acc_ff <= 32'd0;
      end else begin
         acc_ff <= acc_in;
      end
   end

endmodule

`default_nettype wire

### sv/idrq_queue.sv
`default_nettype none

module idrq_queue
   import idrq_pkg::*;
#(
   parameter int DEPTH = 2
) (
   input  wire logic             clock,
   input  wire logic             reset,
   input  wire logic             push,
   input  wire job_type          push_job,
   input  wire logic             pop,
   output job_type               head_job,
   output queue_status_type      status
);

   localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
   localparam int CNT_W = $clog2(DEPTH + 1);

   job_type          entries_ff [DEPTH];
   logic [PTR_W-1:0] wr_ptr_ff, wr_ptr_in;
   logic [PTR_W-1:0] rd_ptr_ff, rd_ptr_in;
   logic [CNT_W-1:0] count_ff, count_in;

   assign status.full  = (count_ff == CNT_W'(DEPTH));
   assign status.empty = (count_ff == '0);
   assign head_job     = entries_ff[rd_ptr_ff];

   // Pointer and fill count update.
   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (push) begin
         wr_ptr_in = (wr_ptr_ff == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_ff + 1'b1;
      end
      if (pop) begin
         rd_ptr_in = (rd_ptr_ff == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_ff + 1'b1;
      end
      if (push && !pop) begin
         count_in = count_ff + 1'b1;
      end else if (pop && !push) begin
         count_in = count_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   // Entry storage needs no reset.
   always_ff @(posedge clock) begin
      if (push) begin
         entries_ff[wr_ptr_ff] <= push_job;
      end
   end

endmodule

`default_nettype wire

### sv/idrq_back.sv
`default_nettype none

module idrq_back
   import idrq_pkg::*;
(
   input  wire logic             clock,
   input  wire logic             reset,
   input  wire cfg_type          cfg,
   input  wire queue_status_type q_status,
   input  wire job_type          q_head,
   output logic                  q_pop,
   output logic                  rsp_valid,
   input  wire logic             rsp_ready,
   output logic signed [7:0]     rsp_neuron_out
);

   back_state_type     state_ff, state_in;
   job_type            job_ff, job_in;
   logic [63:0]        prod_ff, prod_in;
   logic               min_min_ff, min_min_in;
   logic [31:0]        high_ff, high_in;
   logic [31:0]        quot_ff, quot_in;
   logic               rsp_valid_ff, rsp_valid_in;
   logic signed [7:0]  rsp_data_ff, rsp_data_in;

   logic [63:0]        rounded;
   logic [31:0]        mask;
   logic [31:0]        remainder;
   logic [31:0]        threshold;
   logic signed [32:0] biased;
   logic signed [32:0] out_zp;
   logic signed [32:0] clamped;

   assign rsp_valid      = rsp_valid_ff;
   assign rsp_neuron_out = rsp_data_ff;

   // Datapath terms of each step.
   always_comb begin
      rounded   = prod_ff + HALF_Q31;
      mask      = (32'd1 << job_ff.shift) - 32'd1;
      remainder = high_ff & mask;
      threshold = (mask >> 1) + {31'd0, high_ff[31]};
      out_zp    = {{25{cfg.out_zero_pt[7]}}, cfg.out_zero_pt};
      biased    = $signed({quot_ff[31], quot_ff}) + out_zp;
      if (biased > S8_POS_LIMIT) begin
         clamped = S8_POS_LIMIT;
      end else if (biased < S8_NEG_LIMIT) begin
         clamped = S8_NEG_LIMIT;
      end else begin
         clamped = biased;
      end
      if (cfg.relu_en && (clamped < out_zp)) begin
         clamped = out_zp;
      end
   end

   // Sequencer: multiply, high word, rounding shift, then saturate into the output.
   always_comb begin
      state_in     = state_ff;
      job_in       = job_ff;
      prod_in      = prod_ff;
      min_min_in   = min_min_ff;
      high_in      = high_ff;
      quot_in      = quot_ff;
      rsp_data_in  = rsp_data_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_ready;
      q_pop        = 1'b0;
      unique case (state_ff)
         ST_IDLE: begin
            if (!q_status.empty) begin
               q_pop    = 1'b1;
               job_in   = q_head;
               state_in = ST_MUL;
            end
         end
         ST_MUL: begin
            prod_in    = 64'($signed(job_ff.sum)) * 64'($signed(job_ff.multiplier));
            min_min_in = (job_ff.sum == S32_NEG_LIMIT)
                      && (job_ff.multiplier == S32_NEG_LIMIT);
            state_in   = ST_HMUL;
         end
         ST_HMUL: begin
            high_in  = min_min_ff ? S32_POS_LIMIT : rounded[62:31];
            state_in = ST_RSH;
         end
         ST_RSH: begin
            quot_in  = 32'($signed(high_ff) >>> job_ff.shift)
                     + {31'd0, (remainder > threshold)};
            state_in = ST_OUT;
         end
         ST_OUT: begin
            if (!rsp_valid_ff || rsp_ready) begin
               rsp_data_in  = clamped[7:0];
               rsp_valid_in = 1'b1;
               state_in     = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   // Payload registers carry no reset.
   always_ff @(posedge clock) begin
      job_ff      <= job_in;
      prod_ff     <= prod_in;
      min_min_ff  <= min_min_in;
      high_ff     <= high_in;
      quot_ff     <= quot_in;
      rsp_data_ff <= rsp_data_in;
   end

endmodule

`default_nettype wire

### sim/tb.sv
`timescale 1ns / 1ps

module tb
   import idrq_pkg::*;
();

   // Register index past the end of the register list; writes to it are dropped.
   localparam logic [1:0] CSR_UNUSED = 2'd3;

   // Run limit in clock cycles, far beyond the slowest correct run.
   localparam int CYCLE_LIMIT = 200_000;

   // One dot product term as it is offered on the request channel.
   typedef struct {
      logic signed [7:0] activation;
      logic signed [7:0] weight;
      logic signed [7:0] weight_zp;
      logic [31:0]       bias;
      logic [31:0]       multiplier;
      logic [4:0]        shift;
      logic              last_term;
   } term_type;

   logic                    clock;
   logic                    reset;
   logic                    csr_valid;
   logic                    csr_ready;
   logic [1:0]              csr_index;
   logic [7:0]              csr_wdata;
   logic                    req_valid;
   logic                    req_ready;
   logic signed [7:0]       req_activation;
   logic signed [7:0]       req_weight;
   logic signed [7:0]       req_weight_zero_point;
   logic [31:0]             req_bias;
   logic [31:0]             req_multiplier;
   logic [4:0]              req_shift;
   logic                    req_last_term;
   logic                    rsp_valid;
   logic                    rsp_ready;
   logic signed [7:0]       rsp_neuron_out;

   // Terms waiting to be offered, and neuron values waiting to come back.
   term_type                pending_terms[$];
   logic signed [7:0]       neuron_expect[$];

   // Shadow of the block's configuration and accumulator.
   cfg_type                 cfg_shadow;
   logic [31:0]             dot_acc;

   term_type                offered_term;
   int                      terms_accepted;
   int                      mismatches;
   int                      cycles;
   logic                    calm;

   int8_dense_requant_mac uut (
      .clock                 (clock),
      .reset                 (reset),
      .csr_valid             (csr_valid),
      .csr_ready             (csr_ready),
      .csr_index             (csr_index),
      .csr_wdata             (csr_wdata),
      .req_valid             (req_valid),
      .req_ready             (req_ready),
      .req_activation        (req_activation),
      .req_weight            (req_weight),
      .req_weight_zero_point (req_weight_zero_point),
      .req_bias              (req_bias),
      .req_multiplier        (req_multiplier),
      .req_shift             (req_shift),
      .req_last_term         (req_last_term),
      .rsp_valid             (rsp_valid),
      .rsp_ready             (rsp_ready),
      .rsp_neuron_out        (rsp_neuron_out)
   );

   initial begin
      clock = 1'b0;
      forever #5 clock = ~clock;
   end

   // Requantize a finished sum: Q31 high multiply, rounding shift, offset, clamps.
   function automatic logic signed [7:0] requantize(input logic [31:0] sum,
                                                    input logic [31:0] mult,
                                                    input logic [4:0]  sh);
      longint      prod;
      logic [31:0] high;
      logic [31:0] mask;
      logic [31:0] rem;
      logic [31:0] thr;
      logic [31:0] quot;
      longint      val;
      if (sum == S32_NEG_LIMIT && mult == S32_NEG_LIMIT) begin
         high = S32_POS_LIMIT;
      end else begin
         prod = longint'($signed(sum)) * longint'($signed(mult)) + HALF_Q31;
         high = prod[62:31];
      end
      // Round half away from zero: negative values need a strictly larger remainder.
      mask = (32'd1 << sh) - 32'd1;
      rem  = high & mask;
      thr  = (mask >> 1) + {31'd0, high[31]};
      quot = $signed(high) >>> sh;
      quot = quot + {31'd0, rem > thr};
      val  = longint'($signed(quot)) + longint'(cfg_shadow.out_zero_pt);
      if (val > 127) val = 127;
      if (val < -128) val = -128;
      if (cfg_shadow.relu_en && val < longint'(cfg_shadow.out_zero_pt)) begin
         val = longint'(cfg_shadow.out_zero_pt);
      end
      return val[7:0];
   endfunction

   // Fold one accepted term into the shadow sum; a last term yields a neuron value.
   task automatic accumulate_term(input term_type t);
      int x;
      int w;
      x = int'(t.activation) - int'(cfg_shadow.in_zero_pt);
      w = int'(t.weight) - int'(t.weight_zp);
      dot_acc = dot_acc + 32'(x * w);
      if (t.last_term) begin
         dot_acc = dot_acc + t.bias;
         neuron_expect.push_back(requantize(dot_acc, t.multiplier, t.shift));
         dot_acc = '0;
      end
   endtask

   function automatic term_type make_term(input logic signed [7:0] act,
                                          input logic signed [7:0] wt,
                                          input logic signed [7:0] wzp,
                                          input logic [31:0] bias,
                                          input logic [31:0] mult,
                                          input logic [4:0] sh,
                                          input logic last);
      term_type t;
      t.activation = act;
      t.weight     = wt;
      t.weight_zp  = wzp;
      t.bias       = bias;
      t.multiplier = mult;
      t.shift      = sh;
      t.last_term  = last;
      return t;
   endfunction

   // Random term; bias, multiplier and shift lean toward values that do not saturate.
   function automatic term_type random_term(input logic last);
      term_type    t;
      logic [31:0] r;
      t.activation = 8'($urandom);
      t.weight     = 8'($urandom);
      t.weight_zp  = 8'($urandom);
      r = $urandom;
      t.bias = ($urandom_range(0, 3) == 0) ? r : {{16{r[15]}}, r[15:0]};
      r = $urandom;
      case ($urandom_range(0, 3))
         0: t.multiplier = r;
         1: t.multiplier = {2'b01, r[29:0]};
         2: t.multiplier = {2'b10, r[29:0]};
         default: t.multiplier = S32_POS_LIMIT;
      endcase
      t.shift = ($urandom_range(0, 1) == 1) ? 5'($urandom_range(0, 31))
                                            : 5'($urandom_range(0, 14));
      t.last_term = last;
      return t;
   endfunction

   function automatic logic [7:0] random_zp();
      if ($urandom_range(0, 3) == 0) begin
         return ($urandom_range(0, 1) == 1) ? 8'h80 : 8'h7f;
      end
      return 8'($urandom);
   endfunction

   // One register transfer; the shadow copy follows once it is accepted.
   task automatic write_csr(input logic [1:0] idx, input logic [7:0] data);
      @(posedge clock);
      csr_valid <= 1'b1;
      csr_index <= idx;
      csr_wdata <= data;
      do @(posedge clock); while (!csr_ready);
      csr_valid <= 1'b0;
      case (idx)
         CSR_INPUT_ZP:  cfg_shadow.in_zero_pt  = data;
         CSR_OUTPUT_ZP: cfg_shadow.out_zero_pt = data;
         CSR_RELU_EN:   cfg_shadow.relu_en     = data[0];
         default: ;
      endcase
   endtask

   // Wait for every term to be taken and every neuron value to return, then let
   // the back end settle.
   task automatic wait_drained();
      do @(negedge clock);
      while (!(pending_terms.size() == 0 && !req_valid && neuron_expect.size() == 0));
      repeat (10) @(posedge clock);
   endtask

   task automatic write_all_csrs(input logic [7:0] izp, input logic [7:0] ozp,
                                 input logic relu);
      write_csr(CSR_INPUT_ZP, izp);
      write_csr(CSR_OUTPUT_ZP, ozp);
      write_csr(CSR_UNUSED, 8'($urandom));
      write_csr(CSR_RELU_EN, {7'($urandom), relu});
   endtask

   // Stimulus: directed phases at the configuration extremes, then random phases.
   initial begin : stimulus
      int n;
      int len;
      reset          = 1'b1;
      csr_valid      = 1'b0;
      csr_index      = '0;
      csr_wdata      = '0;
      calm           = 1'b0;
      cfg_shadow     = '0;
      dot_acc        = '0;
      terms_accepted = 0;
      mismatches     = 0;
      repeat (6) @(posedge clock);
      reset <= 1'b0;

      // Reset values, with a dropped write to the unused index.
      write_all_csrs(8'h00, 8'h00, 1'b0);
      // A non-last term carries junk in its bias, multiplier and shift.
      pending_terms.push_back(make_term(127, -128, 127, 32'hffff_ffff, S32_NEG_LIMIT, 31, 0));
      pending_terms.push_back(make_term(-128, 127, -128, 0, S32_POS_LIMIT, 0, 1));
      // The one overflowing high multiply, with and without the widest shift.
      pending_terms.push_back(make_term(0, 0, 0, S32_NEG_LIMIT, S32_NEG_LIMIT, 0, 1));
      pending_terms.push_back(make_term(0, 0, 0, S32_NEG_LIMIT, S32_NEG_LIMIT, 31, 1));
      // Bias addition wraps past the top of the int32 range.
      pending_terms.push_back(make_term(127, 127, -128, 0, 0, 0, 0));
      pending_terms.push_back(make_term(0, 0, 0, S32_POS_LIMIT, S32_POS_LIMIT, 24, 1));
      // Exact halves round away from zero on both sides.
      pending_terms.push_back(make_term(0, 5, 0, 3, S32_POS_LIMIT, 1, 1));
      pending_terms.push_back(make_term(0, 0, 0, 32'hffff_fffd, S32_POS_LIMIT, 1, 1));
      pending_terms.push_back(make_term(0, 0, 0, 32'hffff_fffb, S32_POS_LIMIT, 2, 1));
      pending_terms.push_back(make_term(-1, -1, 0, 100, 32'h0, 5, 1));
      pending_terms.push_back(make_term(3, 4, 1, 1000, 32'hc000_0000, 3, 1));
      wait_drained();

      write_all_csrs(8'h80, 8'h7f, 1'b1);
      pending_terms.push_back(make_term(127, 127, -128, 0, S32_POS_LIMIT, 31, 0));
      pending_terms.push_back(make_term(-128, 0, 0, 0, S32_POS_LIMIT, 31, 1));
      pending_terms.push_back(make_term(0, 0, 0, 32'hffff_ff9c, S32_POS_LIMIT, 0, 1));
      wait_drained();

      write_all_csrs(8'h7f, 8'h80, 1'b0);
      pending_terms.push_back(make_term(127, -128, -128, 50, S32_POS_LIMIT, 0, 1));
      pending_terms.push_back(make_term(-128, 127, -128, 0, S32_POS_LIMIT, 8, 1));
      wait_drained();

      // The ReLU floor at a negative output zero point.
      write_all_csrs(8'd5, 8'hf6, 1'b1);
      pending_terms.push_back(make_term(0, 0, 0, 32'hffff_ffec, S32_POS_LIMIT, 0, 1));
      pending_terms.push_back(make_term(0, 0, 0, 20, S32_POS_LIMIT, 0, 1));
      wait_drained();

      // Random phases; the third runs with no idling on either side.
      for (int phase = 0; phase < 4; phase++) begin
         write_all_csrs(random_zp(), random_zp(), 1'($urandom_range(0, 1)));
         calm = (phase == 2);
         n = 0;
         while (n < 200) begin
            if ($urandom_range(0, 99) < 85) begin
               len = ($urandom_range(0, 9) == 0) ? $urandom_range(11, 40)
                                                 : $urandom_range(1, 10);
               for (int i = 0; i < len; i++) begin
                  pending_terms.push_back(random_term(i == len - 1));
               end
               n += len;
            end else begin
               pending_terms.push_back(random_term(1'($urandom_range(0, 1))));
               n++;
            end
         end
         pending_terms.push_back(random_term(1'b1));
         wait_drained();
      end

      repeat (20) @(posedge clock);
      if (mismatches == 0) begin
         $display("SUCCESS");
      end else begin
         $display("FAILURE");
      end
      $finish;
   end

   // Request driver: offers the next pending term and holds it until its transfer.
   always @(posedge clock) begin : req_driver
      if (reset) begin
         req_valid <= 1'b0;
      end else begin
         if (req_valid && req_ready) begin
            accumulate_term(offered_term);
            terms_accepted++;
         end
         if (!req_valid || req_ready) begin
            if (pending_terms.size() > 0 && (calm || $urandom_range(0, 99) >= 30)) begin
               offered_term <= pending_terms.pop_front();
               req_valid    <= 1'b1;
            end else begin
               req_valid <= 1'b0;
            end
         end
      end
   end

   assign req_activation        = offered_term.activation;
   assign req_weight            = offered_term.weight;
   assign req_weight_zero_point = offered_term.weight_zp;
   assign req_bias              = offered_term.bias;
   assign req_multiplier        = offered_term.multiplier;
   assign req_shift             = offered_term.shift;
   assign req_last_term         = offered_term.last_term;

   initial begin
      offered_term = make_term(0, 0, 0, 0, 0, 0, 0);
   end

   // Response ready: random stalls, plus one long hold-off so the neuron queue
   // fills and the request side backs up.
   always @(posedge clock) begin : rsp_backpressure
      int  hold_left;
      logic hold_done;
      if (reset) begin
         rsp_ready <= 1'b0;
         hold_left = 0;
         hold_done = 1'b0;
      end else if (hold_left > 0) begin
         rsp_ready <= 1'b0;
         hold_left--;
      end else if (!hold_done && terms_accepted >= 300) begin
         rsp_ready <= 1'b0;
         hold_left = 80;
         hold_done = 1'b1;
      end else begin
         rsp_ready <= calm || $urandom_range(0, 99) >= 30;
      end
   end

   // Response monitor: each transfer is checked against the oldest neuron value.
   always @(posedge clock) begin : rsp_monitor
      logic signed [7:0] want;
      if (!reset && rsp_valid && rsp_ready) begin
         if (neuron_expect.size() == 0) begin
            $error("neuron_out: no value expected, actual %0d", rsp_neuron_out);
            mismatches++;
         end else begin
            want = neuron_expect.pop_front();
            if (rsp_neuron_out !== want) begin
               $error("neuron_out: expected %0d, actual %0d", want, rsp_neuron_out);
               mismatches++;
            end
         end
      end
   end

   // Watchdog on the whole run.
   initial cycles = 0;
   always @(posedge clock) begin : watchdog
      cycles++;
      if (cycles >= CYCLE_LIMIT) begin
         $display("FAILURE");
         $finish;
      end
   end

endmodule
